// ===== hw/rtl/stic_pkg.sv =====
package stic_pkg;

  localparam int ValW   = 64;
  localparam int CharW  = 8;
  localparam int RadixW = 6;
  localparam int DigitW = 6;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  // Width of the accumulator product before the overflow check.
  localparam int ProdW  = ValW + RadixW;

  // Queue between the character front end and the accumulator.
  localparam int QDepth = 2;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  localparam logic [RadixW-1:0] MaxRadix = RadixW'(36);
  localparam logic [RadixW-1:0] DecRadix = RadixW'(10);
  localparam logic [RadixW-1:0] HexRadix = RadixW'(16);
  localparam logic [RadixW-1:0] BinRadix = RadixW'(2);

  localparam logic [CharW-1:0] ChMinus   = 8'h2d;
  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChLowX    = 8'h78;
  localparam logic [CharW-1:0] ChUpX     = 8'h58;
  localparam logic [CharW-1:0] ChLowB    = 8'h62;
  localparam logic [CharW-1:0] ChUpB     = 8'h42;
  localparam logic [CharW-1:0] ChLowA    = 8'h61;
  localparam logic [CharW-1:0] ChLowZ    = 8'h7a;
  localparam logic [CharW-1:0] CaseOff   = 8'h20;
  localparam logic [CharW-1:0] LetterGap = 8'd7;
  localparam logic [CharW-1:0] DecDigits = 8'd10;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] RegRadix  = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegSigned = 2'd2;

  // Output width codes.
  localparam logic [1:0] Width8  = 2'd0;
  localparam logic [1:0] Width16 = 2'd1;
  localparam logic [1:0] Width32 = 2'd2;
  localparam logic [1:0] Width64 = 2'd3;

  typedef enum logic [1:0] {
    K_DIGIT,
    K_INVALID,
    K_MINUS,
    K_SKIP
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [DigitW-1:0]  digit;
    logic [RadixW-1:0]  radix;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [RadixW-1:0] radix_setting;
    logic [1:0]        out_width_code;
    logic              signed_out;
  } cfg_t;

endpackage

// ===== hw/rtl/stic_if.sv =====
interface stic_in_if;
  logic                     valid;
  logic                     ready;
  logic [stic_pkg::CharW-1:0] ch;
  logic                     last;

  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

interface stic_out_if;
  logic                      valid;
  logic                      ready;
  logic [stic_pkg::ValW-1:0] value;
  logic [1:0]                status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

// ===== hw/rtl/stic_front.sv =====
module stic_front (
  input  logic                  clk,
  input  logic                  rst,
  stic_in_if.sink               chars,
  input  stic_pkg::cfg_t        cfg,
  input  logic                  q_ready,
  output logic                  push,
  output stic_pkg::item_t       item
);

  logic [1:0]                    pos;
  logic [1:0]                    pos_next;
  logic [stic_pkg::RadixW-1:0]   ar;
  logic [stic_pkg::RadixW-1:0]   ar_next;
  logic                          fwz;
  logic [stic_pkg::RadixW-1:0]   radix;
  logic                          skip;
  logic                          bad;
  logic [stic_pkg::CharW-1:0]    c;
  logic [stic_pkg::CharW-1:0]    folded;
  logic [stic_pkg::CharW-1:0]    d0;
  logic [stic_pkg::CharW-1:0]    d1;

  assign chars.ready = q_ready;
  assign push        = chars.valid && q_ready;
  assign c           = chars.ch;
  assign pos_next    = (pos == 2'd2) ? pos : pos + 2'd1;

  always_comb begin
    skip = 1'b0;
    if (pos == 2'd0) begin
      ar_next = (cfg.radix_setting > stic_pkg::MaxRadix) ? stic_pkg::MaxRadix
                                                        : cfg.radix_setting;
    end else begin
      ar_next = ar;
    end
    // The second character settles an automatic radix: a prefix counts only
    // when more characters follow it.
    if (pos == 2'd1 && ar == '0) begin
      if (fwz && !chars.last && (c == stic_pkg::ChLowX || c == stic_pkg::ChUpX)) begin
        ar_next = stic_pkg::HexRadix;
        skip    = 1'b1;
      end else if (fwz && !chars.last &&
                   (c == stic_pkg::ChLowB || c == stic_pkg::ChUpB)) begin
        ar_next = stic_pkg::BinRadix;
        skip    = 1'b1;
      end else begin
        ar_next = stic_pkg::DecRadix;
      end
    end
    radix = (ar_next == '0) ? stic_pkg::DecRadix : ar_next;

    folded = (c inside {[stic_pkg::ChLowA:stic_pkg::ChLowZ]}) ? c - stic_pkg::CaseOff : c;
    d0     = folded - stic_pkg::ChZero;
    d1     = (d0 >= stic_pkg::DecDigits) ? d0 - stic_pkg::LetterGap : d0;
    bad    = c[stic_pkg::CharW-1] || (folded < stic_pkg::ChZero) ||
             ((d0 >= stic_pkg::DecDigits) && (d1 < stic_pkg::DecDigits)) ||
             (d1 >= {2'b00, radix});

    item.digit = d1[stic_pkg::DigitW-1:0];
    item.radix = radix;
    item.last  = chars.last;
    if (pos == 2'd0 && radix == stic_pkg::DecRadix && c == stic_pkg::ChMinus) begin
      item.kind = stic_pkg::K_MINUS;
    end else if (skip) begin
      item.kind = stic_pkg::K_SKIP;
    end else if (bad) begin
      item.kind = stic_pkg::K_INVALID;
    end else begin
      item.kind = stic_pkg::K_DIGIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      ar  <= '0;
      fwz <= 1'b0;
    end else if (push) begin
      if (chars.last) begin
        pos <= '0;
        ar  <= '0;
        fwz <= 1'b0;
      end else begin
        pos <= pos_next;
        ar  <= ar_next;
        if (pos == 2'd0 && item.kind != stic_pkg::K_MINUS) begin
          fwz <= (c == stic_pkg::ChZero);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/stic_queue.sv =====
module stic_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  stic_pkg::item_t wr_item,
  output logic            ready,
  input  logic            pop,
  output logic            rd_valid,
  output stic_pkg::item_t rd_item
);

  stic_pkg::item_t             mem [stic_pkg::QDepth];
  logic [stic_pkg::PtrW-1:0]   wr_ptr;
  logic [stic_pkg::PtrW-1:0]   rd_ptr;
  logic [stic_pkg::CntW-1:0]   count;

  assign ready    = (count != stic_pkg::CntW'(stic_pkg::QDepth));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + stic_pkg::PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + stic_pkg::PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + stic_pkg::CntW'(1);
      end else if (pop && !push) begin
        count <= count - stic_pkg::CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/stic_back.sv =====
module stic_back (
  input  logic            clk,
  input  logic            rst,
  input  stic_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  stic_pkg::item_t item,
  output logic            pop,
  stic_out_if.source      results
);

  logic [stic_pkg::ValW-1:0]  acc;
  logic [stic_pkg::ValW-1:0]  acc_next;
  stic_pkg::status_t          err;
  stic_pkg::status_t          err_next;
  logic                       neg;
  logic                       neg_next;
  logic [stic_pkg::ProdW-1:0] sum;
  logic                       ovf;

  logic                      fin_valid;
  logic [stic_pkg::ValW-1:0] fin_acc;
  stic_pkg::status_t         fin_err;
  logic                      fin_neg;
  logic                      fin_ready;
  logic                      out_free;

  logic [stic_pkg::ValW-1:0] full;
  logic [stic_pkg::ValW-1:0] lim;
  logic [stic_pkg::ValW-1:0] val;
  stic_pkg::status_t         st;

  assign out_free  = !results.valid || results.ready;
  assign fin_ready = !fin_valid || out_free;
  assign pop       = q_valid && (!item.last || fin_ready);

  // A carry into the top bits of the widened product means the magnitude
  // no longer fits in 64 bits.
  assign sum = ({{stic_pkg::RadixW{1'b0}}, acc} * {{stic_pkg::ValW{1'b0}}, item.radix}) +
               {{stic_pkg::ValW{1'b0}}, item.digit};
  assign ovf = |sum[stic_pkg::ProdW-1:stic_pkg::ValW];

  always_comb begin
    acc_next = acc;
    err_next = err;
    neg_next = neg;
    case (item.kind)
      stic_pkg::K_INVALID: begin
        err_next = stic_pkg::ST_INVALID;
      end
      stic_pkg::K_DIGIT: begin
        if (err == stic_pkg::ST_OK) begin
          if (ovf) begin
            err_next = stic_pkg::ST_RANGE;
          end else begin
            acc_next = sum[stic_pkg::ValW-1:0];
          end
        end
      end
      stic_pkg::K_MINUS: begin
        neg_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      err       <= stic_pkg::ST_OK;
      neg       <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (item.last) begin
          acc <= '0;
          err <= stic_pkg::ST_OK;
          neg <= 1'b0;
        end else begin
          acc <= acc_next;
          err <= err_next;
          neg <= neg_next;
        end
      end
      if (pop && item.last) begin
        fin_valid <= 1'b1;
      end else if (out_free) begin
        fin_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.last) begin
      fin_acc <= acc_next;
      fin_err <= err_next;
      fin_neg <= neg_next;
    end
  end

  // Range check, negation and truncation on the finished magnitude.
  always_comb begin
    case (cfg.out_width_code)
      stic_pkg::Width8:  full = stic_pkg::ValW'(8'hff);
      stic_pkg::Width16: full = stic_pkg::ValW'(16'hffff);
      stic_pkg::Width32: full = stic_pkg::ValW'(32'hffff_ffff);
      default:           full = '1;
    endcase
    lim = (cfg.signed_out || fin_neg) ? (full >> 1) : full;
    if (fin_neg) begin
      lim = lim + stic_pkg::ValW'(1);
    end
    if (fin_err != stic_pkg::ST_OK) begin
      st = fin_err;
    end else if (fin_acc > lim) begin
      st = stic_pkg::ST_RANGE;
    end else begin
      st = stic_pkg::ST_OK;
    end
    val = (st == stic_pkg::ST_OK) ? ((fin_neg ? ('0 - fin_acc) : fin_acc) & full) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_free) begin
      results.valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fin_valid) begin
      results.value  <= val;
      results.status <= st;
    end
  end

endmodule

// ===== hw/rtl/string_to_integer_converter_top.sv =====
// Channel   Role      Beat payload
// chars     sink      ch (8 bits), last (1 bit)
// results   source    value (64 bits), status (2 bits), one beat per string
// apb       slave     radix_setting @0x0, out_width_code @0x4, signed_out @0x8
//
// One character beat is taken every cycle while the two-entry queue between
// the character classifier and the accumulator has room.
// The accumulator does one 64x6 multiply-add per cycle while the queue holds
// an item; a finished result goes via the finish stage to the output register.
// A stalled result holds in the output register while the finish stage and the
// queue absorb the next strings; rst is synchronous and reloads the defaults.
module string_to_integer_converter_top (
  input  logic                        clk,
  input  logic                        rst,
  stic_in_if.sink                     chars,
  stic_out_if.source                  results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stic_pkg::AddrW-1:0]  paddr,
  input  logic [stic_pkg::DataW-1:0]  pwdata,
  output logic [stic_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  stic_pkg::cfg_t  cfg;
  stic_pkg::item_t f_item;
  stic_pkg::item_t q_item;
  logic            push;
  logic            q_ready;
  logic            q_valid;
  logic            q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix_setting  <= '0;
      cfg.out_width_code <= stic_pkg::Width64;
      cfg.signed_out     <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        stic_pkg::RegRadix:  cfg.radix_setting  <= pwdata[stic_pkg::RadixW-1:0];
        stic_pkg::RegWidth:  cfg.out_width_code <= pwdata[1:0];
        stic_pkg::RegSigned: cfg.signed_out     <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      stic_pkg::RegRadix:  prdata = stic_pkg::DataW'(cfg.radix_setting);
      stic_pkg::RegWidth:  prdata = stic_pkg::DataW'(cfg.out_width_code);
      stic_pkg::RegSigned: prdata = stic_pkg::DataW'(cfg.signed_out);
      default:             prdata = '0;
    endcase
  end

  stic_front u_front (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .cfg     (cfg),
    .q_ready (q_ready),
    .push    (push),
    .item    (f_item)
  );

  stic_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (f_item),
    .ready    (q_ready),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  stic_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .item    (q_item),
    .pop     (q_pop),
    .results (results)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("accumulator popped an empty queue");

  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status != stic_pkg::ST_OK) |-> (results.value == '0))
    else $error("failed conversion carries a nonzero value");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !results.valid)
    else $error("result valid after reset");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stic_pkg::*;

  typedef struct packed {
    logic [ValW-1:0] value;
    status_t         status;
  } conv_result_t;

  // One directed numeral with the settings it runs under.
  typedef struct {
    logic [RadixW-1:0] radix;
    logic [1:0]        wcode;
    logic              sgn;
    string             txt;
    bit                typed;
    logic [ValW-1:0]   value;
    status_t           status;
  } numeral_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  stic_in_if  chars_if ();
  stic_out_if results_if ();

  string_to_integer_converter_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Settings as the block holds them, and the conversion state of the string in flight.
  cfg_t              cfg = '{radix_setting: '0, out_width_code: 2'd3, signed_out: 1'b1};
  logic [ValW-1:0]   mag_acc = '0;
  logic [1:0]        char_pos = '0;
  logic [RadixW-1:0] base_now = '0;
  logic              lead_zero = 1'b0;
  logic              minus_seen = 1'b0;
  status_t           sticky_err = ST_OK;

  conv_result_t      pending_results[$];
  logic [CharW-1:0]  numeral[$];
  int                fail_count = 0;
  int                chars_sent = 0;
  bit                idle_on = 1'b1;
  int                rx_hold_req = 0;

  numeral_row_t steps [13] = '{
    '{6'd0,  2'd3, 1'b1, "-",    1'b1, 64'd0,                  ST_OK},
    '{6'd0,  2'd3, 1'b1, "-5",   1'b1, 64'hFFFF_FFFF_FFFF_FFFB, ST_OK},
    '{6'd0,  2'd3, 1'b1, "0x",   1'b1, 64'd0,                  ST_INVALID},
    '{6'd0,  2'd3, 1'b1, "0xf",  1'b0, 64'd0,                  ST_OK},
    '{6'd0,  2'd3, 1'b1, "0B1",  1'b1, 64'd1,                  ST_OK},
    '{6'd0,  2'd3, 1'b1, "\377", 1'b1, 64'd0,                  ST_INVALID},
    '{6'd0,  2'd3, 1'b1, "A",    1'b1, 64'd0,                  ST_INVALID},
    '{6'd36, 2'd0, 1'b0, "73",   1'b0, 64'd0,                  ST_OK},
    '{6'd36, 2'd0, 1'b0, "74",   1'b1, 64'd0,                  ST_RANGE},
    '{6'd36, 2'd3, 1'b0, "ZZZZZZZZZZZZZ", 1'b1, 64'd0,         ST_RANGE},
    '{6'd63, 2'd1, 1'b1, "z",    1'b1, 64'd35,                 ST_OK},
    '{6'd1,  2'd2, 1'b0, "0",    1'b1, 64'd0,                  ST_OK},
    '{6'd1,  2'd2, 1'b0, "1",    1'b1, 64'd0,                  ST_INVALID}
  };

  function automatic void flag_error(status_t code);
    if (sticky_err != ST_INVALID) begin
      if (code == ST_INVALID) sticky_err = ST_INVALID;
      else if (sticky_err == ST_OK) sticky_err = code;
    end
  endfunction

  function automatic void add_digit(logic [CharW-1:0] c_in, logic [RadixW-1:0] radix);
    logic [CharW-1:0] c;
    logic [CharW-1:0] d;
    c = c_in;
    if (c[CharW-1]) begin
      flag_error(ST_INVALID);
      return;
    end
    if (c >= ChLowA && c <= ChLowZ) c = c - CaseOff;
    if (c < ChZero) begin
      flag_error(ST_INVALID);
      return;
    end
    d = c - ChZero;
    if (d >= DecDigits) begin
      d = d - LetterGap;
      // Punctuation between '9' and 'A' lands below ten after the letter shift.
      if (d < DecDigits) begin
        flag_error(ST_INVALID);
        return;
      end
    end
    if (d >= CharW'(radix)) begin
      flag_error(ST_INVALID);
      return;
    end
    if (sticky_err != ST_OK) return;
    if (mag_acc > ({ValW{1'b1}} - ValW'(d)) / ValW'(radix)) begin
      flag_error(ST_RANGE);
      return;
    end
    mag_acc = mag_acc * ValW'(radix) + ValW'(d);
  endfunction

  // Advances the conversion by one character; returns 1 when a result is due.
  function automatic bit convert_char(input logic [CharW-1:0] c, input logic lst,
                                      output logic [ValW-1:0] val, output status_t st);
    logic [RadixW-1:0] radix;
    logic [ValW-1:0]   lim;
    bit                skip;
    int                bits;
    val = '0;
    st = ST_OK;
    skip = 1'b0;
    if (char_pos == 2'd0) begin
      base_now = (cfg.radix_setting > MaxRadix) ? MaxRadix : cfg.radix_setting;
      radix = (base_now == '0) ? DecRadix : base_now;
      if (radix == DecRadix && c == ChMinus) begin
        minus_seen = 1'b1;
      end else begin
        lead_zero = (c == ChZero);
        add_digit(c, radix);
      end
    end else begin
      if (char_pos == 2'd1 && base_now == '0) begin
        if (lead_zero && !lst && (c == ChLowX || c == ChUpX)) begin
          base_now = HexRadix;
          skip = 1'b1;
        end else if (lead_zero && !lst && (c == ChLowB || c == ChUpB)) begin
          base_now = BinRadix;
          skip = 1'b1;
        end else begin
          base_now = DecRadix;
        end
      end
      radix = (base_now == '0) ? DecRadix : base_now;
      if (!skip) add_digit(c, radix);
    end
    if (char_pos < 2'd2) char_pos = char_pos + 2'd1;
    if (!lst) return 1'b0;

    bits = 8 << cfg.out_width_code;
    lim = (bits >= 64) ? {ValW{1'b1}} : (ValW'(1) << bits) - ValW'(1);
    if (cfg.signed_out || minus_seen) begin
      lim = lim >> 1;
      if (minus_seen) lim = lim + ValW'(1);
    end
    if (sticky_err == ST_OK && mag_acc > lim) sticky_err = ST_RANGE;
    if (sticky_err == ST_OK) begin
      val = minus_seen ? -mag_acc : mag_acc;
      if (bits < 64) val = val & ((ValW'(1) << bits) - ValW'(1));
    end
    st = sticky_err;
    mag_acc = '0;
    char_pos = '0;
    base_now = '0;
    lead_zero = 1'b0;
    minus_seen = 1'b0;
    sticky_err = ST_OK;
    return 1'b1;
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_regs(input logic [RadixW-1:0] r, input logic [1:0] w, input logic s);
    apb_write(RegRadix, DataW'(r));
    apb_write(RegWidth, DataW'(w));
    apb_write(RegSigned, DataW'(s));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg = '{radix_setting: r, out_width_code: w, signed_out: s};
  endtask

  // Drops valid, waits until every pending result is in, then idles before returning.
  task automatic drain_block();
    chars_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_char(input logic [CharW-1:0] c, input logic lst, input bit typed,
                           input logic [ValW-1:0] tval, input status_t tstat);
    int gap;
    logic [ValW-1:0] pv;
    status_t ps;
    conv_result_t r;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch <= c;
    chars_if.last <= lst;
    do @(posedge clk); while (!chars_if.ready);
    chars_sent++;
    if (convert_char(c, lst, pv, ps)) begin
      if (typed) begin
        r.value = tval;
        r.status = tstat;
      end else begin
        r.value = pv;
        r.status = ps;
      end
      pending_results.push_back(r);
    end
  endtask

  // Mostly well-formed numerals aimed at the magnitude limits, with some noise mixed in.
  task automatic build_numeral();
    logic [RadixW-1:0] r;
    logic [ValW-1:0]   lim;
    logic [ValW-1:0]   mag;
    logic [CharW-1:0]  d;
    logic [CharW-1:0]  digs[$];
    logic [CharW-1:0]  c;
    bit                neg;
    int                bits;
    numeral.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 6)) numeral.push_back(CharW'($urandom));
      return;
    end
    r = (cfg.radix_setting > MaxRadix) ? MaxRadix : cfg.radix_setting;
    if (r == '0) begin
      case ($urandom_range(0, 3))
        0: begin
          numeral.push_back(ChZero);
          numeral.push_back($urandom_range(0, 1) ? ChLowX : ChUpX);
          r = HexRadix;
        end
        1: begin
          numeral.push_back(ChZero);
          numeral.push_back($urandom_range(0, 1) ? ChLowB : ChUpB);
          r = BinRadix;
        end
        default: r = DecRadix;
      endcase
    end
    neg = (r == DecRadix && numeral.size() == 0 && $urandom_range(0, 2) == 0);
    if (neg) numeral.push_back(ChMinus);

    bits = 8 << cfg.out_width_code;
    lim = (bits >= 64) ? {ValW{1'b1}} : (ValW'(1) << bits) - ValW'(1);
    if (cfg.signed_out || neg) begin
      lim = lim >> 1;
      if (neg) lim = lim + ValW'(1);
    end
    case ($urandom_range(0, 6))
      0: mag = '0;
      1: mag = lim;
      2: mag = lim + ValW'(1);
      3: mag = lim - ValW'(1);
      4: mag = {$urandom, $urandom};
      default: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    // Radix one only knows the digit zero.
    if (r == RadixW'(1)) mag = '0;
    do begin
      digs.push_front(CharW'(mag % ValW'(r)));
      mag = mag / ValW'(r);
    end while (mag != '0);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) digs.push_front('0);
    // An extra digit pushes large values past the 64-bit accumulator.
    if ($urandom_range(0, 9) == 0) digs.push_back(CharW'($urandom_range(0, r - 1)));
    foreach (digs[i]) begin
      d = digs[i];
      if (d < DecDigits) c = ChZero + d;
      else c = ChZero + d + LetterGap + ($urandom_range(0, 1) ? CaseOff : '0);
      numeral.push_back(c);
    end
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0: c = ChMinus;
        1: c = ChLowX;
        2: c = ChUpB;
        3: c = CharW'($urandom_range(128, 255));
        default: c = CharW'($urandom);
      endcase
      numeral.insert($urandom_range(0, numeral.size()), c);
    end
  endtask

  task automatic send_numeral();
    for (int i = 0; i < numeral.size(); i++) begin
      send_char(numeral[i], i == numeral.size() - 1, 1'b0, '0, ST_OK);
    end
  endtask

  initial begin
    logic [RadixW-1:0] r;
    logic [1:0]        w;
    logic              s;
    int                phase;
    int                start;
    int                strings;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    chars_if.valid <= 1'b0;
    chars_if.ch <= '0;
    chars_if.last <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[k]) begin
      if (steps[k].radix != cfg.radix_setting || steps[k].wcode != cfg.out_width_code ||
          steps[k].sgn != cfg.signed_out) begin
        drain_block();
        program_regs(steps[k].radix, steps[k].wcode, steps[k].sgn);
      end
      for (int i = 0; i < steps[k].txt.len(); i++) begin
        send_char(steps[k].txt[i], i == steps[k].txt.len() - 1, steps[k].typed,
                  steps[k].value, steps[k].status);
      end
    end

    phase = 0;
    while (chars_sent < 1050) begin
      case (phase)
        0: begin r = 6'd0;  w = 2'd0; s = 1'b1; end
        1: begin r = 6'd36; w = 2'd3; s = 1'b0; end
        2: begin r = 6'd10; w = 2'd0; s = 1'b0; end
        3: begin r = 6'd0;  w = 2'd3; s = 1'b0; end
        default: begin
          case ($urandom_range(0, 7))
            0, 1: r = '0;
            2: r = MaxRadix;
            3: r = RadixW'($urandom_range(37, 63));
            4: r = RadixW'(1);
            5: r = BinRadix;
            6: r = DecRadix;
            default: r = RadixW'($urandom_range(1, 36));
          endcase
          w = 2'($urandom_range(0, 3));
          s = 1'($urandom_range(0, 1));
        end
      endcase
      drain_block();
      program_regs(r, w, s);
      idle_on = (phase % 3 != 1);
      // Long receiver stall: the block fills up and pushes back on its input.
      if (phase == 1) rx_hold_req = 250;
      start = chars_sent;
      strings = 0;
      while (chars_sent - start < 80) begin
        if (phase == 2 && strings == 10) drain_block();
        build_numeral();
        send_numeral();
        strings++;
      end
      phase++;
    end

    drain_block();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int gap;
    conv_result_t want;
    results_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (rx_hold_req > 0) begin
        gap = rx_hold_req;
        rx_hold_req = 0;
      end
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (results_if.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: value %h status %0d",
                   results_if.value, results_if.status);
      end else begin
        want = pending_results.pop_front();
        if (results_if.value !== want.value || results_if.status !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result mismatch: value exp %h got %h, status exp %0d got %0d",
                     want.value, results_if.value, want.status, results_if.status);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/stic_pkg.sv
hw/rtl/stic_if.sv
hw/rtl/stic_front.sv
hw/rtl/stic_queue.sv
hw/rtl/stic_back.sv
hw/rtl/string_to_integer_converter_top.sv
tb/sv/tb_top.sv
